// File: design/irs_pkg.sv
// shared types, constants and helpers for the integer to radix symbol converter
`timescale 1ns / 1ps
`default_nettype none

package irs_pkg;

	localparam int SYM_SLOTS = 16;
	localparam int SYM_IDX_W = 4;
	localparam int SYM_W     = 8;
	localparam int COUNT_W   = 5;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 32;
	localparam int ALPHA_W   = SYM_SLOTS * SYM_W;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [COUNT_W-1:0] SYMBOL_COUNT_RST = 5'd10;
	localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RST  = 64'h3736353433323130;
	localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RST = 64'h0;

	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;

	// result of the alphabet check, done pulses for one cycle
	typedef struct packed {
		logic done;
		logic ok;
	} chk_t;

	function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
			input logic [SYM_IDX_W-1:0] idx);
		return alpha[{idx, 3'b000} +: SYM_W];
	endfunction

endpackage

`default_nettype wire

// File: design/irs_check.sv
// alphabet check, one symbol per cycle against the earlier ones
`timescale 1ns / 1ps
`default_nettype none

module irs_check #(
	parameter int MAX_SYMBOLS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [irs_pkg::COUNT_W-1:0]           symbol_count,
	input  wire  [irs_pkg::ALPHA_W-1:0]           alpha,
	output irs_pkg::chk_t                         result
);
	import irs_pkg::*;

	logic                 busy_q;
	logic [SYM_IDX_W-1:0] idx_q;
	chk_t                 res_q;

	logic [SYM_W-1:0]   cur_sym;
	logic               bad_char;
	logic               dup;
	logic               count_bad;
	logic               at_end;

	assign cur_sym   = sym_at(alpha, idx_q);
	assign bad_char  = (cur_sym == CHAR_PLUS) || (cur_sym == CHAR_MINUS) ||
		(cur_sym == CHAR_SPACE);
	assign count_bad = (symbol_count < 5'd2) || (symbol_count > COUNT_W'(MAX_SYMBOLS));
	assign at_end    = ({1'b0, idx_q} == (symbol_count - 5'd1));

	// compare against every earlier slot in parallel
	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < SYM_SLOTS; j++) begin
			if ((SYM_IDX_W'(j) < idx_q) && (sym_at(alpha, SYM_IDX_W'(j)) == cur_sym))
				dup = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			res_q  <= '0;
		end else begin
			if (start) begin
				idx_q <= '0;
				if (count_bad) begin
					res_q  <= '{done: 1'b1, ok: 1'b0};
					busy_q <= 1'b0;
				end else begin
					res_q.done <= 1'b0;
					busy_q     <= 1'b1;
				end
			end else if (busy_q) begin
				if (bad_char || dup) begin
					res_q  <= '{done: 1'b1, ok: 1'b0};
					busy_q <= 1'b0;
				end else if (at_end) begin
					res_q  <= '{done: 1'b1, ok: 1'b1};
					busy_q <= 1'b0;
				end else begin
					res_q.done <= 1'b0;
					idx_q      <= idx_q + 1'b1;
				end
			end else begin
				res_q.done <= 1'b0;
			end
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// File: design/irs_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module irs_divider #(
	parameter int VALUE_BITS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [VALUE_BITS-1:0]            dividend,
	input  wire  [irs_pkg::COUNT_W-1:0]      radix,
	output logic                             done,
	output logic [VALUE_BITS-1:0]            quotient,
	output logic [irs_pkg::SYM_IDX_W-1:0]    remainder
);
	import irs_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VALUE_BITS-1:0] q_q;
	logic [SYM_IDX_W-1:0] r_q;

	logic [COUNT_W-1:0]   trial;
	logic                 fits;

	// remainder stays below radix, so it fits in the symbol index width
	assign trial = {r_q, q_q[VALUE_BITS-1]};
	assign fits  = (trial >= radix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_BITS-2:0], fits};
			r_q <= fits ? SYM_IDX_W'(trial - radix) : SYM_IDX_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

`default_nettype wire

// File: design/irs_digit_stack.sv
// last-in first-out shift register holding digit indices
`timescale 1ns / 1ps
`default_nettype none

module irs_digit_stack #(
	parameter int DEPTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push,
	input  wire                              pop,
	input  wire  [irs_pkg::SYM_IDX_W-1:0]    din,
	output logic [irs_pkg::SYM_IDX_W-1:0]    dout,
	output logic [$clog2(DEPTH+1)-1:0]       count
);
	import irs_pkg::*;

	localparam int STACK_W = DEPTH * SYM_IDX_W;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	logic [STACK_W-1:0] stack_q;
	logic [CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// newest digit sits in the low nibble
	always_ff @(posedge clk) begin
		if (push)
			stack_q <= {stack_q[STACK_W-SYM_IDX_W-1:0], din};
		else if (pop)
			stack_q <= {{SYM_IDX_W{1'b0}}, stack_q[STACK_W-1:SYM_IDX_W]};
	end

	assign dout  = stack_q[SYM_IDX_W-1:0];
	assign count = cnt_q;

endmodule

`default_nettype wire

// File: design/integer_to_radix_symbols_core.sv
// top level: signed integer to symbols in a configured radix
//
// channel  direction  transaction carries
// s_*      in         tdata[31:0] value
// m_*      out        tdata[7:0] symbol, tlast last, tuser alphabet_error
// cfg_*    in         register write, index 0..2, data up to 64 bits
//
// one value at a time; the alphabet check runs before the division
// each digit is a full pass of the bit-serial divider, then symbols leave
// one per cycle from the output register while m_tready is high
// m_tready low holds the output register and the sign, error and emit states
// until it rises; s_tready is high when idle
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_symbols_core #(
	parameter int MAX_SYMBOLS = 16,
	parameter int VALUE_BITS  = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [irs_pkg::IN_W-1:0]         s_tdata,   // [31:0] value
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [irs_pkg::SYM_W-1:0]        m_tdata,   // [7:0] symbol
	output logic                             m_tlast,
	output logic                             m_tuser,   // [0] alphabet_error
	input  wire                              cfg_wr_en,
	input  wire  [irs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [irs_pkg::CFG_W-1:0]        cfg_data
);
	import irs_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_ERR      = 3'd2;
	localparam logic [2:0] S_SIGN     = 3'd3;
	localparam logic [2:0] S_DIV_GO   = 3'd4;
	localparam logic [2:0] S_DIV_WAIT = 3'd5;
	localparam logic [2:0] S_EMIT     = 3'd6;

	logic [COUNT_W-1:0]    symbol_count_q;
	logic [CFG_W-1:0]      symbols_low_q;
	logic [CFG_W-1:0]      symbols_high_q;
	logic [ALPHA_W-1:0]    alpha;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] raw_q;
	logic [VALUE_BITS-1:0] mag_q;

	logic                  out_valid_q;
	logic [SYM_W-1:0]      out_sym_q;
	logic                  out_last_q;
	logic                  out_err_q;

	logic                  in_take;
	logic                  out_free;
	chk_t                  chk;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [SYM_IDX_W-1:0]  div_rem;
	logic                  push;
	logic                  pop;
	logic [SYM_IDX_W-1:0]  top_digit;
	logic [CNT_W-1:0]      digit_cnt;

	assign alpha    = {symbols_high_q, symbols_low_q};
	assign s_tready = (state_q == S_IDLE);
	assign in_take  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign push     = (state_q == S_DIV_WAIT) && div_done;
	assign pop      = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= SYMBOL_COUNT_RST;
			symbols_low_q  <= SYMBOLS_LOW_RST;
			symbols_high_q <= SYMBOLS_HIGH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SYMBOL_COUNT: symbol_count_q <= cfg_data[COUNT_W-1:0];
				REG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data;
				REG_SYMBOLS_HIGH: symbols_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	irs_check #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_take),
		.symbol_count(symbol_count_q),
		.alpha       (alpha),
		.result      (chk)
	);

	irs_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_GO),
		.dividend (mag_q),
		.radix    (symbol_count_q),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	irs_digit_stack #(
		.DEPTH(VALUE_BITS)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.din   (div_rem),
		.dout  (top_digit),
		.count (digit_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:
					if (in_take)
						state_q <= S_CHECK;
				S_CHECK:
					if (chk.done) begin
						if (!chk.ok)
							state_q <= S_ERR;
						else if (raw_q[VALUE_BITS-1])
							state_q <= S_SIGN;
						else
							state_q <= S_DIV_GO;
					end
				S_ERR:
					if (out_free)
						state_q <= S_IDLE;
				S_SIGN:
					if (out_free)
						state_q <= S_DIV_GO;
				S_DIV_GO:
					state_q <= S_DIV_WAIT;
				S_DIV_WAIT:
					if (div_done)
						state_q <= (div_quot == '0) ? S_EMIT : S_DIV_GO;
				S_EMIT:
					if (out_free && (digit_cnt == CNT_W'(1)))
						state_q <= S_IDLE;
				default:
					state_q <= S_IDLE;
			endcase
		end
	end

	// most negative value negates onto itself, which is its magnitude
	always_ff @(posedge clk) begin
		if (in_take)
			raw_q <= s_tdata[VALUE_BITS-1:0];
		if ((state_q == S_CHECK) && chk.done)
			mag_q <= raw_q[VALUE_BITS-1] ? (~raw_q + 1'b1) : raw_q;
		else if (push)
			mag_q <= div_quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_ERR) || (state_q == S_SIGN) ||
				(state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				S_ERR: begin
					out_sym_q  <= '0;
					out_last_q <= 1'b1;
					out_err_q  <= 1'b1;
				end
				S_SIGN: begin
					out_sym_q  <= CHAR_MINUS;
					out_last_q <= 1'b0;
					out_err_q  <= 1'b0;
				end
				S_EMIT: begin
					out_sym_q  <= sym_at(alpha, top_digit);
					out_last_q <= (digit_cnt == CNT_W'(1));
					out_err_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

`default_nettype wire
